FILE: sv/lap3_pkg.sv
// Shared types and constants for the seven-point 3D Laplacian block.
`default_nettype none

package lap3_pkg;

    // Field and register widths.
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CELLS_W   = 5;
    localparam int SIDES_W   = 6;

    // Arithmetic widths: second difference, partial product, scaled term, sum.
    localparam int DIFF_W     = 35;
    localparam int PROD_W     = 52;
    localparam int TERM_W     = 52;
    localparam int SUM_W      = 54;
    localparam int TERM_MAG_W = 50;
    localparam int FRAC_W     = 16;
    localparam int NUM_AXES   = 3;

    // Bit positions in boundary_sides.
    localparam int SIDE_X_LO = 0;
    localparam int SIDE_X_HI = 1;
    localparam int SIDE_Y_LO = 2;
    localparam int SIDE_Y_HI = 3;
    localparam int SIDE_Z_LO = 4;
    localparam int SIDE_Z_HI = 5;

    // Reset values of the configuration registers.
    localparam logic [CELLS_W-1:0] CELLS_RESET = 5'd16;
    localparam logic [CFG_W-1:0]   RECIP_RESET = 32'h0001_0000;
    localparam logic [SIDES_W-1:0] SIDES_RESET = 6'd0;

    // Saturation limits of the result.
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_X    = 3'd0,
        REG_CELLS_Y    = 3'd1,
        REG_CELLS_Z    = 3'd2,
        REG_RECIP_X    = 3'd3,
        REG_RECIP_Y    = 3'd4,
        REG_RECIP_Z    = 3'd5,
        REG_BOUNDARY   = 3'd6
    } lap3_reg_t;

    // Position flags of one grid sample.
    typedef struct packed {
        logic interior;
        logic last_cell;
        logic x_lo;
        logic x_hi;
        logic y_lo;
        logic y_hi;
        logic z_lo;
        logic z_hi;
    } lap3_flags_t;

    // Stencil operands of one interior cell.
    typedef struct packed {
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] dn;
        logic [DATA_W-1:0] up;
        logic [DATA_W-1:0] bl;
        logic [DATA_W-1:0] ab;
    } lap3_ops_t;

endpackage

`default_nettype wire

FILE: sv/laplacian_stencil_3d.sv
// Top level of the streamed seven-point 3D Laplacian with its register file.
`default_nettype none

// The block takes one ghost-padded field of (cells_x+2) x (cells_y+2) x
// (cells_z+2) samples per pass, in raster order with x fastest, and returns
// one Laplacian beat for every interior cell, in raster order, with tlast on
// the last interior cell. It accepts one sample beat per clock unless the
// result stream holds it back. The three most recent padded planes live in
// two identical copies of a plane store of 3*(MAX_CELLS+2)^2 words, each
// with two read ports, so the four stored neighbors of a cell are fetched
// in the single cycle in which the sample above it arrives; the x neighbors
// come from a two-word shift line fed by a look-ahead read. The store needs
// no clearing after reset: every word read for a result was written earlier
// in the same pass. Writing cells_x, cells_y or cells_z restarts the pass at
// the first sample; the other registers act at once. The user writes
// configuration only while no results are outstanding; the block itself
// does not enforce this.
module laplacian_stencil_3d #(
    parameter int MAX_CELLS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port.
    input  wire logic                                cfg_wen,
    input  wire logic [lap3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lap3_pkg::CFG_W-1:0]          cfg_data,
    // Sample stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lap3_pkg::DATA_W-1:0]         s_axis_tdata,  // [31:0] sample
    // Result stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lap3_pkg::DATA_W-1:0]              m_axis_tdata,  // [31:0] laplacian
    output logic                                     m_axis_tlast   // final_cell
);

    localparam int SPAN  = MAX_CELLS + 2;
    localparam int DEPTH = 3 * SPAN * SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = lap3_pkg::DATA_W;

    logic [lap3_pkg::CELLS_W-1:0] cells_x_reg, cells_y_reg, cells_z_reg;
    logic [lap3_pkg::CFG_W-1:0]   recip_x_reg, recip_y_reg, recip_z_reg;
    logic [lap3_pkg::SIDES_W-1:0] sides_reg;
    logic                         restart;

    logic                         accept;
    logic                         en1;
    logic                         s1_leave;
    logic                         arith_ready;
    logic                         v1_reg;
    lap3_pkg::lap3_flags_t        flags1_reg;
    logic [DW-1:0]                ab1_reg;
    logic [DW-1:0]                sh_c_reg, sh_l_reg;

    logic [AW-1:0]                wr_addr, ahead_addr, dn_addr, up_addr, bl_addr;
    lap3_pkg::lap3_flags_t        pos_flags;
    logic [DW-1:0]                rd_ahead, rd_dn, rd_up, rd_bl;
    lap3_pkg::lap3_ops_t          ops;

    // Register writes; a size write restarts the pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= lap3_pkg::CELLS_RESET;
            cells_y_reg <= lap3_pkg::CELLS_RESET;
            cells_z_reg <= lap3_pkg::CELLS_RESET;
            recip_x_reg <= lap3_pkg::RECIP_RESET;
            recip_y_reg <= lap3_pkg::RECIP_RESET;
            recip_z_reg <= lap3_pkg::RECIP_RESET;
            sides_reg   <= lap3_pkg::SIDES_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                lap3_pkg::REG_CELLS_X:  cells_x_reg <= cfg_data[lap3_pkg::CELLS_W-1:0];
                lap3_pkg::REG_CELLS_Y:  cells_y_reg <= cfg_data[lap3_pkg::CELLS_W-1:0];
                lap3_pkg::REG_CELLS_Z:  cells_z_reg <= cfg_data[lap3_pkg::CELLS_W-1:0];
                lap3_pkg::REG_RECIP_X:  recip_x_reg <= cfg_data;
                lap3_pkg::REG_RECIP_Y:  recip_y_reg <= cfg_data;
                lap3_pkg::REG_RECIP_Z:  recip_z_reg <= cfg_data;
                lap3_pkg::REG_BOUNDARY: sides_reg   <= cfg_data[lap3_pkg::SIDES_W-1:0];
                default:                ;
            endcase
        end
    end

    assign restart = cfg_wen && ((cfg_index == lap3_pkg::REG_CELLS_X) ||
                                 (cfg_index == lap3_pkg::REG_CELLS_Y) ||
                                 (cfg_index == lap3_pkg::REG_CELLS_Z));

    // Input handshake: the fetch stage takes a beat whenever it can move on.
    assign en1           = !v1_reg || arith_ready;
    assign s1_leave      = v1_reg && arith_ready;
    assign s_axis_tready = en1;
    assign accept        = s_axis_tvalid && en1;

    lap3_addr #(
        .MAX_CELLS (MAX_CELLS)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (accept),
        .restart    (restart),
        .cells_x    (cells_x_reg),
        .cells_y    (cells_y_reg),
        .cells_z    (cells_z_reg),
        .wr_addr    (wr_addr),
        .ahead_addr (ahead_addr),
        .dn_addr    (dn_addr),
        .up_addr    (up_addr),
        .bl_addr    (bl_addr),
        .flags      (pos_flags)
    );

    // Two copies of the plane store, written alike, four reads per beat.
    lap3_ram #(
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk    (clk),
        .wen    (accept),
        .waddr  (wr_addr),
        .wdata  (s_axis_tdata),
        .ren    (accept),
        .raddr0 (ahead_addr),
        .raddr1 (dn_addr),
        .rdata0 (rd_ahead),
        .rdata1 (rd_dn)
    );

    lap3_ram #(
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk    (clk),
        .wen    (accept),
        .waddr  (wr_addr),
        .wdata  (s_axis_tdata),
        .ren    (accept),
        .raddr0 (up_addr),
        .raddr1 (bl_addr),
        .rdata0 (rd_up),
        .rdata1 (rd_bl)
    );

    // Fetch stage: holds the sample while the store read completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags1_reg <= pos_flags;
            ab1_reg    <= s_axis_tdata;
        end
        // The look-ahead words of the last two beats give center and left.
        if (s1_leave)
        begin
            sh_c_reg <= rd_ahead;
            sh_l_reg <= sh_c_reg;
        end
    end

    always_comb
    begin
        ops.l  = sh_l_reg;
        ops.c  = sh_c_reg;
        ops.r  = rd_ahead;
        ops.dn = rd_dn;
        ops.up = rd_up;
        ops.bl = rd_bl;
        ops.ab = ab1_reg;
    end

    lap3_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg && flags1_reg.interior),
        .in_ready  (arith_ready),
        .ops       (ops),
        .flags     (flags1_reg),
        .sides     (sides_reg),
        .recip_x   (recip_x_reg),
        .recip_y   (recip_y_reg),
        .recip_z   (recip_z_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/lap3_ram.sv
// Plane store memory: one write port, two registered read ports.
`default_nettype none

module lap3_ram #(
    parameter int DEPTH = 972
) (
    input  wire logic                              clk,
    input  wire logic                              wen,
    input  wire logic [$clog2(DEPTH)-1:0]          waddr,
    input  wire logic [lap3_pkg::DATA_W-1:0]       wdata,
    input  wire logic                              ren,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr0,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr1,
    output logic      [lap3_pkg::DATA_W-1:0]       rdata0,
    output logic      [lap3_pkg::DATA_W-1:0]       rdata1
);

    logic [lap3_pkg::DATA_W-1:0] store_mem [DEPTH];
    logic [lap3_pkg::DATA_W-1:0] rd0_reg;
    logic [lap3_pkg::DATA_W-1:0] rd1_reg;

    // Write and read; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            store_mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rd0_reg <= store_mem[raddr0];
            rd1_reg <= store_mem[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

`default_nettype wire

FILE: sv/lap3_addr.sv
// Raster position counters, plane slot rotation and store address generation.
`default_nettype none

module lap3_addr #(
    parameter int MAX_CELLS = 16
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            adv,
    input  wire logic                                            restart,
    input  wire logic [lap3_pkg::CELLS_W-1:0]                    cells_x,
    input  wire logic [lap3_pkg::CELLS_W-1:0]                    cells_y,
    input  wire logic [lap3_pkg::CELLS_W-1:0]                    cells_z,
    output logic [$clog2(3*(MAX_CELLS+2)*(MAX_CELLS+2))-1:0]     wr_addr,
    output logic [$clog2(3*(MAX_CELLS+2)*(MAX_CELLS+2))-1:0]     ahead_addr,
    output logic [$clog2(3*(MAX_CELLS+2)*(MAX_CELLS+2))-1:0]     dn_addr,
    output logic [$clog2(3*(MAX_CELLS+2)*(MAX_CELLS+2))-1:0]     up_addr,
    output logic [$clog2(3*(MAX_CELLS+2)*(MAX_CELLS+2))-1:0]     bl_addr,
    output lap3_pkg::lap3_flags_t                                flags
);

    localparam int SPAN  = MAX_CELLS + 2;
    localparam int PLANE = SPAN * SPAN;
    localparam int DEPTH = 3 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SPAN);
    localparam logic [AW-1:0] SPAN_A = AW'(SPAN);

    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [CW-1:0] pz_reg, pz_next;
    logic [AW-1:0] row_reg, row_next;
    logic [1:0]    slot_cur_reg, slot_cur_next;
    logic [1:0]    slot_m1_reg, slot_m1_next;
    logic [1:0]    slot_m2_reg, slot_m2_next;

    logic [CW-1:0] cx, cy, cz;
    logic [CW-1:0] x_last, y_last, z_last;
    logic          last_col, last_row, last_plane;
    logic [AW-1:0] xa;
    logic [AW-1:0] base_cur, base_m1, base_m2;
    logic [AW-1:0] ahead_off;

    // Cell count as used: zero acts as one, anything above the maximum is clamped.
    function automatic logic [CW-1:0] eff_cells(input logic [lap3_pkg::CELLS_W-1:0] n);
        logic [CW-1:0] res;
        if (n == '0)
        begin
            res = CW'(1);
        end
        else if (32'(n) > 32'(MAX_CELLS))
        begin
            res = CW'(MAX_CELLS);
        end
        else
        begin
            res = CW'(n);
        end
        return res;
    endfunction

    // Start address of a plane slot.
    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] res;
        case (s)
            2'd1:    res = AW'(PLANE);
            2'd2:    res = AW'(2 * PLANE);
            default: res = '0;
        endcase
        return res;
    endfunction

    // Effective sizes and end-of-line tests.
    always_comb
    begin
        cx         = eff_cells(cells_x);
        cy         = eff_cells(cells_y);
        cz         = eff_cells(cells_z);
        x_last     = cx + CW'(1);
        y_last     = cy + CW'(1);
        z_last     = cz + CW'(1);
        last_col   = (px_reg == x_last);
        last_row   = (py_reg == y_last);
        last_plane = (pz_reg == z_last);
    end

    // Position flags of the sample now at the input.
    always_comb
    begin
        flags.interior  = (px_reg != '0) && (px_reg <= cx) && (py_reg != '0) &&
                          (py_reg <= cy) && (pz_reg >= CW'(2)) && (pz_reg <= z_last);
        flags.last_cell = (px_reg == cx) && (py_reg == cy) && (pz_reg == z_last);
        flags.x_lo      = (px_reg == CW'(1));
        flags.x_hi      = (px_reg == cx);
        flags.y_lo      = (py_reg == CW'(1));
        flags.y_hi      = (py_reg == cy);
        flags.z_lo      = (pz_reg == CW'(2));
        flags.z_hi      = (pz_reg == z_last);
    end

    // Store addresses: the write slot takes this plane, reads come from the two
    // planes below. The look-ahead read fetches the next sample of the plane
    // below, which feeds the x neighbors through a short shift line.
    always_comb
    begin
        xa       = AW'(px_reg);
        base_cur = slot_base(slot_cur_reg);
        base_m1  = slot_base(slot_m1_reg);
        base_m2  = slot_base(slot_m2_reg);
        if (last_col)
        begin
            ahead_off = last_row ? '0 : row_reg + SPAN_A;
        end
        else
        begin
            ahead_off = row_reg + xa + AW'(1);
        end
        wr_addr    = base_cur + row_reg + xa;
        ahead_addr = base_m1 + ahead_off;
        dn_addr    = base_m1 + ((py_reg == '0) ? xa : (row_reg - SPAN_A + xa));
        up_addr    = base_m1 + (last_row ? xa : (row_reg + SPAN_A + xa));
        bl_addr    = base_m2 + row_reg + xa;
    end

    // Next position and plane slot rotation.
    always_comb
    begin
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        row_next      = row_reg;
        slot_cur_next = slot_cur_reg;
        slot_m1_next  = slot_m1_reg;
        slot_m2_next  = slot_m2_reg;
        if (restart)
        begin
            px_next       = '0;
            py_next       = '0;
            pz_next       = '0;
            row_next      = '0;
            slot_cur_next = 2'd0;
            slot_m1_next  = 2'd2;
            slot_m2_next  = 2'd1;
        end
        else if (adv)
        begin
            if (!last_col)
            begin
                px_next = px_reg + CW'(1);
            end
            else
            begin
                px_next = '0;
                if (!last_row)
                begin
                    py_next  = py_reg + CW'(1);
                    row_next = row_reg + SPAN_A;
                end
                else
                begin
                    py_next  = '0;
                    row_next = '0;
                    if (last_plane)
                    begin
                        pz_next       = '0;
                        slot_cur_next = 2'd0;
                        slot_m1_next  = 2'd2;
                        slot_m2_next  = 2'd1;
                    end
                    else
                    begin
                        pz_next       = pz_reg + CW'(1);
                        slot_cur_next = (slot_cur_reg == 2'd2) ? 2'd0 : slot_cur_reg + 2'd1;
                        slot_m1_next  = slot_cur_reg;
                        slot_m2_next  = slot_m1_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg       <= '0;
            py_reg       <= '0;
            pz_reg       <= '0;
            row_reg      <= '0;
            slot_cur_reg <= 2'd0;
            slot_m1_reg  <= 2'd2;
            slot_m2_reg  <= 2'd1;
        end
        else
        begin
            px_reg       <= px_next;
            py_reg       <= py_next;
            pz_reg       <= pz_next;
            row_reg      <= row_next;
            slot_cur_reg <= slot_cur_next;
            slot_m1_reg  <= slot_m1_next;
            slot_m2_reg  <= slot_m2_next;
        end
    end

    // A size change puts the position back to the first sample.
    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (px_reg == '0 && py_reg == '0 && pz_reg == '0 && row_reg == '0))
        else $error("position not cleared after restart");

    // The three plane slots stay distinct and valid.
    a_slots_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_cur_reg != slot_m1_reg) && (slot_cur_reg != slot_m2_reg) &&
        (slot_m1_reg != slot_m2_reg) && (slot_cur_reg != 2'd3) &&
        (slot_m1_reg != 2'd3) && (slot_m2_reg != 2'd3))
        else $error("plane slots overlap");

    // The written word is never one of the words read in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> (wr_addr != ahead_addr) && (wr_addr != dn_addr) &&
                (wr_addr != up_addr) && (wr_addr != bl_addr))
        else $error("write address collides with a read address");

    // The position stays inside the padded patch.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (px_reg <= x_last) && (py_reg <= y_last) && (pz_reg <= z_last))
        else $error("position outside the padded patch");

endmodule

`default_nettype wire

FILE: sv/lap3_arith.sv
// Stencil arithmetic pipeline: boundary fix-up, scaling, summation, saturation.
`default_nettype none

module lap3_arith (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire lap3_pkg::lap3_ops_t                 ops,
    input  wire lap3_pkg::lap3_flags_t               flags,
    input  wire logic [lap3_pkg::SIDES_W-1:0]        sides,
    input  wire logic [lap3_pkg::CFG_W-1:0]          recip_x,
    input  wire logic [lap3_pkg::CFG_W-1:0]          recip_y,
    input  wire logic [lap3_pkg::CFG_W-1:0]          recip_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [lap3_pkg::DATA_W-1:0]              out_data,
    output logic                                     out_last
);

    localparam int DW  = lap3_pkg::DATA_W;
    localparam int XW  = lap3_pkg::DIFF_W;
    localparam int PW  = lap3_pkg::PROD_W;
    localparam int TW  = lap3_pkg::TERM_W;
    localparam int SW  = lap3_pkg::SUM_W;
    localparam int NA  = lap3_pkg::NUM_AXES;
    localparam int FW  = lap3_pkg::FRAC_W;
    localparam int MW  = lap3_pkg::TERM_MAG_W;

    logic en2, en3, en4, en5, out_en;
    logic v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic last2_reg, last3_reg, last4_reg, last5_reg, m_last_reg;

    logic signed [DW:0]   c33, neg_c;
    logic signed [DW:0]   xl, xr, yd, yu, zb, za;
    logic signed [XW-1:0] d_next [NA];
    logic signed [XW-1:0] d_reg  [NA];

    logic [DW-1:0]        recip [NA];
    logic signed [PW-1:0] p_hi_next [NA];
    logic signed [PW-1:0] p_lo_next [NA];
    logic signed [PW-1:0] p_hi_reg  [NA];
    logic signed [PW-1:0] p_lo_reg  [NA];

    logic signed [TW-1:0] t_next [NA];
    logic signed [TW-1:0] t_reg  [NA];

    logic signed [SW-1:0] sum_next, sum_reg;
    logic [DW-1:0]        m_data_next, m_data_reg;
    logic                 sum_fits;

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        out_en   = !m_valid_reg || out_ready;
        en5      = !v5_reg || out_en;
        en4      = !v4_reg || en5;
        en3      = !v3_reg || en4;
        en2      = !v2_reg || en3;
        in_ready = en2;
    end

    // Ghost replacement on physical boundaries and the three second differences.
    always_comb
    begin
        c33   = $signed({ops.c[DW-1], ops.c});
        neg_c = -c33;
        xl = (flags.x_lo && sides[lap3_pkg::SIDE_X_LO]) ? neg_c : $signed({ops.l[DW-1], ops.l});
        xr = (flags.x_hi && sides[lap3_pkg::SIDE_X_HI]) ? neg_c : $signed({ops.r[DW-1], ops.r});
        yd = (flags.y_lo && sides[lap3_pkg::SIDE_Y_LO]) ? neg_c : $signed({ops.dn[DW-1], ops.dn});
        yu = (flags.y_hi && sides[lap3_pkg::SIDE_Y_HI]) ? neg_c : $signed({ops.up[DW-1], ops.up});
        zb = (flags.z_lo && sides[lap3_pkg::SIDE_Z_LO]) ? neg_c : $signed({ops.bl[DW-1], ops.bl});
        za = (flags.z_hi && sides[lap3_pkg::SIDE_Z_HI]) ? neg_c : $signed({ops.ab[DW-1], ops.ab});
        d_next[0] = XW'(xl) + XW'(xr) - (XW'(c33) <<< 1);
        d_next[1] = XW'(yd) + XW'(yu) - (XW'(c33) <<< 1);
        d_next[2] = XW'(zb) + XW'(za) - (XW'(c33) <<< 1);
    end

    // Each reciprocal is split into integer and fraction halves, one product each.
    always_comb
    begin
        recip[0] = recip_x;
        recip[1] = recip_y;
        recip[2] = recip_z;
        for (int k = 0; k < NA; k++)
        begin
            p_hi_next[k] = PW'(d_reg[k]) * PW'($signed({1'b0, recip[k][DW-1:FW]}));
            p_lo_next[k] = PW'(d_reg[k]) * PW'($signed({1'b0, recip[k][FW-1:0]}));
        end
    end

    // Scaled terms: the fraction product is floored by an arithmetic shift.
    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            t_next[k] = TW'(p_hi_reg[k]) + TW'(p_lo_reg[k] >>> FW);
        end
        sum_next = SW'(t_reg[0]) + SW'(t_reg[1]) + SW'(t_reg[2]);
    end

    // Saturate the sum to the signed 32-bit range.
    always_comb
    begin
        sum_fits = (&sum_reg[SW-1:DW-1]) || !(|sum_reg[SW-1:DW-1]);
        if (sum_fits)
        begin
            m_data_next = sum_reg[DW-1:0];
        end
        else if (sum_reg[SW-1])
        begin
            m_data_next = lap3_pkg::SAT_MIN;
        end
        else
        begin
            m_data_next = lap3_pkg::SAT_MAX;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= in_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (out_en)
            begin
                m_valid_reg <= v5_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en2 && in_valid)
        begin
            d_reg     <= d_next;
            last2_reg <= flags.last_cell;
        end
        if (en3 && v2_reg)
        begin
            p_hi_reg  <= p_hi_next;
            p_lo_reg  <= p_lo_next;
            last3_reg <= last2_reg;
        end
        if (en4 && v3_reg)
        begin
            t_reg     <= t_next;
            last4_reg <= last3_reg;
        end
        if (en5 && v4_reg)
        begin
            sum_reg   <= sum_next;
            last5_reg <= last4_reg;
        end
        if (out_en && v5_reg)
        begin
            m_data_reg <= m_data_next;
            m_last_reg <= last5_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
    assign out_last  = m_last_reg;

    // An accepted cell always lands in the first stage.
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v2_reg)
        else $error("accepted cell lost at the difference stage");

    // A blocked difference stage keeps its cell.
    a_hold_diff: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en3) |=> (v2_reg && $stable(d_reg[0]) && $stable(d_reg[1]) &&
                              $stable(d_reg[2])))
        else $error("difference stage changed while stalled");

    // Scaled terms stay well inside their register width.
    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (((&t_reg[0][TW-1:MW]) || !(|t_reg[0][TW-1:MW])) &&
                    ((&t_reg[1][TW-1:MW]) || !(|t_reg[1][TW-1:MW])) &&
                    ((&t_reg[2][TW-1:MW]) || !(|t_reg[2][TW-1:MW]))))
        else $error("scaled term out of range");

    // Saturation keeps the sign of the exact sum.
    a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && out_en) |=> (m_data_reg[DW-1] == $past(sum_reg[SW-1])))
        else $error("saturated result has the wrong sign");

endmodule

`default_nettype wire
